// File: src/bbpd_pkg.sv
// ----------------------------------------------------------------------------
// bbpd_pkg
// Shared types and constants for the bang-bang position drive: payload
// structs, configuration block, direction and register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bbpd_pkg;

    // Default values for the top-level parameters
    localparam int RAMP_PERIOD_MS_DEF  = 10;
    localparam int PULSE_CYCLE_LEN_DEF = 30;
    localparam int PULSE_ON_STEPS_DEF  = 5;

    // Soft-start level in thousandths
    localparam int LEVEL_W     = 10;
    localparam int LEVEL_FULL  = 1000;
    localparam int LEVEL_START = 400;

    // Configuration field widths and reset values
    localparam int DEADBAND_W      = 15;
    localparam int PERIOD_W        = 10;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int DEADBAND_RST    = 50;
    localparam int PERIOD_RST      = 150;

    // Error path width: four 16-bit terms summed
    localparam int ERR_W = 18;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE_DRIVE = 2'd0,
        CFG_DEADBAND     = 2'd1,
        CFG_POS_BIAS     = 2'd2,
        CFG_CTRL_PERIOD  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] target_pos;
        logic signed [15:0] actual_pos;
        logic signed [15:0] extra_offset;
        logic               extra_offset_valid;
    } tick_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_a_duty;
        logic [LEVEL_W-1:0] drive_b_duty;
        logic [1:0]         motion_dir;
    } result_t;

    typedef struct packed {
        logic                  enable_drive;
        logic [DEADBAND_W-1:0] deadband;
        logic signed [15:0]    position_bias;
        logic [PERIOD_W-1:0]   control_period_ms;
    } cfg_t;

endpackage

`default_nettype wire

// File: src/bbpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bbpd_cfg_regs
// Configuration register file; takes one write per cycle, always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bbpd_cfg_regs
    import bbpd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Write the addressed register on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_drive      <= 1'b0;
            cfg_reg.deadband          <= DEADBAND_W'(DEADBAND_RST);
            cfg_reg.position_bias     <= '0;
            cfg_reg.control_period_ms <= PERIOD_W'(PERIOD_RST);
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE_DRIVE: cfg_reg.enable_drive      <= cfg_data[0];
                CFG_DEADBAND:     cfg_reg.deadband          <= cfg_data[DEADBAND_W-1:0];
                CFG_POS_BIAS:     cfg_reg.position_bias     <= signed'(cfg_data);
                CFG_CTRL_PERIOD:  cfg_reg.control_period_ms <= cfg_data[PERIOD_W-1:0];
                default:          cfg_reg                   <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/bbpd_in_stage.sv
// ----------------------------------------------------------------------------
// bbpd_in_stage
// Input register: captures one tick and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bbpd_in_stage
    import bbpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  tick_valid,
    output logic       tick_ready,
    input  tick_t      tick,
    output logic       stage_valid,
    output tick_t      stage_item,
    input  wire logic  stage_ready
);

    logic  valid_reg;
    tick_t item_reg;
    logic  load;

    // Accept when empty or when the held tick moves on this cycle
    assign tick_ready  = !valid_reg || stage_ready;
    assign load        = tick_valid && tick_ready;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (stage_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture payload on transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= tick;
        end
    end

endmodule

`default_nettype wire

// File: src/bbpd_core.sv
// ----------------------------------------------------------------------------
// bbpd_core
// Per-tick update: ramp timer and soft-start level, duty refresh, control
// timer, pulse step, error and direction choice, then the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbpd_core
    import bbpd_pkg::*;
#(
    parameter int RAMP_PERIOD_MS  = RAMP_PERIOD_MS_DEF,
    parameter int PULSE_CYCLE_LEN = PULSE_CYCLE_LEN_DEF,
    parameter int PULSE_ON_STEPS  = PULSE_ON_STEPS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  cfg_t       cfg,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  tick_t      item,
    output logic       result_valid,
    input  wire logic  result_ready,
    output result_t    result
);

    localparam int RAMP_TW       = (RAMP_PERIOD_MS > 1) ? $clog2(RAMP_PERIOD_MS) : 1;
    localparam int RAMP_STEP_RAW = ((LEVEL_FULL - LEVEL_START) * RAMP_PERIOD_MS) / 3000;
    localparam int RAMP_STEP     = (RAMP_STEP_RAW == 0) ? 1 : RAMP_STEP_RAW;
    localparam int PULSE_W       = $clog2(PULSE_CYCLE_LEN);
    localparam int ON_W          = 7;

    // State
    logic [RAMP_TW-1:0]  ramp_tick_count_reg,    ramp_tick_count_next;
    logic [PERIOD_W-1:0] control_tick_count_reg, control_tick_count_next;
    logic [PULSE_W-1:0]  pulse_step_reg,         pulse_step_next;
    dir_t                direction_reg,          direction_next;
    logic [LEVEL_W-1:0]  ramp_level_reg,         ramp_level_next;
    logic [LEVEL_W-1:0]  duty_a_hold_reg,        duty_a_hold_next;
    logic [LEVEL_W-1:0]  duty_b_hold_reg,        duty_b_hold_next;

    logic    result_valid_reg;
    result_t result_reg;
    logic    advance;

    // Intermediate terms
    logic                 ramp_fire;
    logic [LEVEL_W:0]     level_sum;
    logic [LEVEL_W-1:0]   level_ramped;
    logic [PERIOD_W-1:0]  period_eff;
    logic                 ctrl_fire;
    logic [PULSE_W:0]     pulse_inc;
    logic                 pulse_on;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]     mag;
    logic [ERR_W-1:0]     triple_db;
    dir_t                 dir_pick;

    // Move a tick in when the result slot is free or being drained
    assign item_ready   = !result_valid_reg || result_ready;
    assign advance      = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Ramp timer, soft-start level and duty refresh
    always_comb
    begin
        ramp_fire = ({1'b0, ramp_tick_count_reg} + 1'b1) >= (RAMP_TW+1)'(RAMP_PERIOD_MS);
        level_sum = {1'b0, ramp_level_reg} + (LEVEL_W+1)'(RAMP_STEP);
        if (level_sum > (LEVEL_W+1)'(LEVEL_FULL))
        begin
            level_ramped = LEVEL_W'(LEVEL_FULL);
        end
        else
        begin
            level_ramped = level_sum[LEVEL_W-1:0];
        end

        ramp_tick_count_next = ramp_fire ? '0 : ramp_tick_count_reg + 1'b1;
        duty_a_hold_next     = duty_a_hold_reg;
        duty_b_hold_next     = duty_b_hold_reg;
        if (ramp_fire)
        begin
            duty_a_hold_next = '0;
            duty_b_hold_next = '0;
            if (cfg.enable_drive && (level_ramped != '0))
            begin
                if (direction_reg == DIR_FWD)
                begin
                    duty_a_hold_next = level_ramped;
                end
                else if (direction_reg == DIR_REV)
                begin
                    duty_b_hold_next = level_ramped;
                end
            end
        end
    end

    // Control timer, pulse step, error and direction choice
    always_comb
    begin
        period_eff = (cfg.control_period_ms == '0) ? PERIOD_W'(1) : cfg.control_period_ms;
        ctrl_fire  = ({1'b0, control_tick_count_reg} + 1'b1) >= {1'b0, period_eff};
        control_tick_count_next = ctrl_fire ? '0 : control_tick_count_reg + 1'b1;

        pulse_inc = {1'b0, pulse_step_reg} + 1'b1;
        if (pulse_inc == (PULSE_W+1)'(PULSE_CYCLE_LEN))
        begin
            pulse_inc = '0;
        end
        pulse_on = ON_W'(pulse_inc) < ON_W'(PULSE_ON_STEPS);

        err = ERR_W'(cfg.position_bias) - ERR_W'(item.target_pos) - ERR_W'(item.actual_pos);
        if (item.extra_offset_valid)
        begin
            err = err + ERR_W'(item.extra_offset);
        end
        mag       = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        triple_db = {3'b000, cfg.deadband} + {2'b00, cfg.deadband, 1'b0};

        if (mag < ERR_W'(cfg.deadband))
        begin
            dir_pick = DIR_STOP;
        end
        else if (pulse_on || (mag > triple_db))
        begin
            dir_pick = (err > 0) ? DIR_FWD : DIR_REV;
        end
        else
        begin
            dir_pick = DIR_STOP;
        end

        pulse_step_next = pulse_step_reg;
        direction_next  = direction_reg;
        ramp_level_next = ramp_fire ? level_ramped : ramp_level_reg;
        if (ctrl_fire)
        begin
            pulse_step_next = pulse_inc[PULSE_W-1:0];
            direction_next  = dir_pick;
            if ((dir_pick != DIR_STOP) && (dir_pick != direction_reg))
            begin
                ramp_level_next = LEVEL_W'(LEVEL_START);
            end
        end
    end

    // Advance state on each tick taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_tick_count_reg    <= '0;
            control_tick_count_reg <= '0;
            pulse_step_reg         <= '0;
            direction_reg          <= DIR_STOP;
            ramp_level_reg         <= '0;
            duty_a_hold_reg        <= '0;
            duty_b_hold_reg        <= '0;
        end
        else if (advance)
        begin
            ramp_tick_count_reg    <= ramp_tick_count_next;
            control_tick_count_reg <= control_tick_count_next;
            pulse_step_reg         <= pulse_step_next;
            direction_reg          <= direction_next;
            ramp_level_reg         <= ramp_level_next;
            duty_a_hold_reg        <= duty_a_hold_next;
            duty_b_hold_reg        <= duty_b_hold_next;
        end
    end

    // Result slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.drive_a_duty <= duty_a_hold_next;
            result_reg.drive_b_duty <= duty_b_hold_next;
            result_reg.motion_dir   <= direction_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bang_bang_position_drive.sv
// ----------------------------------------------------------------------------
// bang_bang_position_drive
// Bang-bang position drive with soft-start ramp; one tick in, one result out.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Transfer when
//  tick      tick_valid / tick_ready / tick            tick_valid && tick_ready
//  result    result_valid / result_ready / result      result_valid && result_ready
//  cfg       cfg_valid / cfg_ready / cfg_index/data    cfg_valid && cfg_ready
//
//  A tick passes from transfer through the input register, then the update
//  logic into the result register. One tick per cycle is sustained while results are taken.
//  Reset clears all timers, level and duties; direction resets to stop.
//  A stalled result holds in its register while the input register still
//  takes one more tick; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module bang_bang_position_drive
    import bbpd_pkg::*;
#(
    parameter int RAMP_PERIOD_MS  = RAMP_PERIOD_MS_DEF,
    parameter int PULSE_CYCLE_LEN = PULSE_CYCLE_LEN_DEF,
    parameter int PULSE_ON_STEPS  = PULSE_ON_STEPS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   tick_valid,
    output logic                        tick_ready,
    input  tick_t                       tick,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_t                     result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    logic  stage_valid;
    logic  stage_ready;
    tick_t stage_item;

    bbpd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bbpd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_ready  (tick_ready),
        .tick        (tick),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .stage_ready (stage_ready)
    );

    bbpd_core #(
        .RAMP_PERIOD_MS  (RAMP_PERIOD_MS),
        .PULSE_CYCLE_LEN (PULSE_CYCLE_LEN),
        .PULSE_ON_STEPS  (PULSE_ON_STEPS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (stage_valid),
        .item_ready   (stage_ready),
        .item         (stage_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Both bridge legs never drive at once
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.drive_a_duty == '0) || (result.drive_b_duty == '0))
        else $error("both bridge legs driven");

    // Duty never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.drive_a_duty <= LEVEL_W'(LEVEL_FULL))
                      && (result.drive_b_duty <= LEVEL_W'(LEVEL_FULL)))
        else $error("duty above full scale");

    // Input side stalls only when both registers are full and output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !tick_ready |-> result_valid && !result_ready)
        else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bang-bang position drive. A model of the soft
// start ramp, pulse stepping and direction choice predicts every result;
// ticks and results move with random gaps, and register settings change only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
    import bbpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LEVEL_STEP_RAW =
        ((LEVEL_FULL - LEVEL_START) * RAMP_PERIOD_MS_DEF) / 3000;
    localparam int LEVEL_STEP = (LEVEL_STEP_RAW == 0) ? 1 : LEVEL_STEP_RAW;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   tick_valid   = 1'b0;
    logic                   tick_ready;
    tick_t                  tick         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = CFG_ENABLE_DRIVE;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // Shadow of the configuration and the drive state
    cfg_t drive_cfg;
    int   ramp_ticks  = 0;
    int   ctrl_ticks  = 0;
    int   pulse_idx   = 0;
    dir_t dir_now     = DIR_STOP;
    int   level       = 0;
    int   duty_fwd    = 0;
    int   duty_rev    = 0;

    result_t bridge_outputs_due[$];
    int      mismatches = 0;
    int      cycles     = 0;
    bit      no_gaps    = 1'b0;

    bang_bang_position_drive uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the drive by one millisecond tick and return its outputs
    function automatic result_t next_bridge_state(tick_t t);
        int      period;
        int      err;
        int      mag;
        int      db;
        dir_t    pick;
        result_t r;
        // ramp and duty refresh use the direction held before this tick
        if (ramp_ticks + 1 >= RAMP_PERIOD_MS_DEF)
        begin
            ramp_ticks = 0;
            level = level + LEVEL_STEP;
            if (level > LEVEL_FULL)
                level = LEVEL_FULL;
            duty_fwd = 0;
            duty_rev = 0;
            if (drive_cfg.enable_drive && level != 0)
            begin
                if (dir_now == DIR_FWD)
                    duty_fwd = level;
                else if (dir_now == DIR_REV)
                    duty_rev = level;
            end
        end
        else
            ramp_ticks++;

        period = (drive_cfg.control_period_ms == 0) ? 1 : int'(drive_cfg.control_period_ms);
        if (ctrl_ticks + 1 >= period)
        begin
            ctrl_ticks = 0;
            pulse_idx = (pulse_idx + 1) % PULSE_CYCLE_LEN_DEF;
            err = -int'($signed(t.target_pos)) + int'($signed(drive_cfg.position_bias))
                  - int'($signed(t.actual_pos));
            if (t.extra_offset_valid)
                err += int'($signed(t.extra_offset));
            mag = (err < 0) ? -err : err;
            db  = int'(drive_cfg.deadband);
            if (mag < db)
                pick = DIR_STOP;
            else if (pulse_idx < PULSE_ON_STEPS_DEF || mag > 3 * db)
                pick = (err > 0) ? DIR_FWD : DIR_REV;
            else
                pick = DIR_STOP;
            // restart the soft start on a fresh direction
            if (pick != DIR_STOP && pick != dir_now)
                level = LEVEL_START;
            dir_now = pick;
        end
        else
            ctrl_ticks++;

        r.drive_a_duty = duty_fwd[LEVEL_W-1:0];
        r.drive_b_duty = duty_rev[LEVEL_W-1:0];
        r.motion_dir   = dir_now;
        return r;
    endfunction

    function automatic tick_t tick_of(int tgt, int act, int ext, bit v);
        tick_t t;
        t.target_pos         = tgt[15:0];
        t.actual_pos         = act[15:0];
        t.extra_offset       = ext[15:0];
        t.extra_offset_valid = v;
        return t;
    endfunction

    // Build a tick with random content whose error comes out as requested
    function automatic tick_t tick_for_error(int err);
        int tgt;
        int ext;
        int act;
        bit v;
        tgt = int'($urandom_range(0, 8000)) - 4000;
        ext = int'($urandom_range(0, 65535)) - 32768;
        v   = 1'($urandom_range(0, 1));
        act = -tgt + int'($signed(drive_cfg.position_bias)) + (v ? ext : 0) - err;
        // fall back to any position when the wanted error does not fit
        if (act < -32768 || act > 32767)
            act = int'($urandom_range(0, 65535)) - 32768;
        return tick_of(tgt, act, ext, v);
    endfunction

    // Aim the error at the deadband and strong-drive boundaries
    function automatic tick_t band_probe_tick();
        int db;
        int mag;
        db = int'(drive_cfg.deadband);
        case ($urandom_range(0, 4))
            0: mag = (db == 0) ? 0 : db - 1;
            1: mag = db;
            2: mag = 3 * db;
            3: mag = 3 * db + 1;
            default: mag = int'($urandom_range(0, 4 * db + 2));
        endcase
        return tick_for_error($urandom_range(0, 1) ? mag : -mag);
    endfunction

    function automatic tick_t raw_tick();
        tick_t t;
        t.target_pos         = 16'($urandom());
        t.actual_pos         = 16'($urandom());
        t.extra_offset       = 16'($urandom());
        t.extra_offset_valid = 1'($urandom());
        return t;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // Send one tick and queue its predicted outputs on transfer
    task automatic send_tick(tick_t t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        do @(posedge clk); while (!tick_ready);
        bridge_outputs_due.push_back(next_bridge_state(t));
    endtask

    // Hold the sender until every queued result has come back
    task automatic drain_results();
        tick_valid <= 1'b0;
        while (bridge_outputs_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLE_DRIVE: drive_cfg.enable_drive      = data[0];
            CFG_DEADBAND:     drive_cfg.deadband          = data[DEADBAND_W-1:0];
            CFG_POS_BIAS:     drive_cfg.position_bias     = data;
            CFG_CTRL_PERIOD:  drive_cfg.control_period_ms = data[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_drive(bit en, int db, int bias, int period);
        drain_results();
        cfg_write(CFG_ENABLE_DRIVE, {15'($urandom()), en});
        cfg_write(CFG_DEADBAND, {1'($urandom()), db[DEADBAND_W-1:0]});
        cfg_write(CFG_POS_BIAS, bias[15:0]);
        cfg_write(CFG_CTRL_PERIOD, {6'($urandom()), period[PERIOD_W-1:0]});
    endtask

    // Run with the reset configuration: drive disabled, slow decisions
    task automatic test_reset_state();
        repeat (15) send_tick(raw_tick());
    endtask

    // Walk the field extremes and the deadband boundaries
    task automatic test_directed_edges();
        set_drive(1'b1, 50, 0, 1);
        send_tick(tick_of(0, 0, 0, 0));
        send_tick(tick_of(-49, 0, 0, 0));
        send_tick(tick_of(-50, 0, 0, 0));
        send_tick(tick_of(150, 0, 0, 0));
        send_tick(tick_of(-151, 0, 0, 0));
        send_tick(tick_of(0, 151, 0, 0));
        send_tick(tick_of(0, 0, -200, 1));
        send_tick(tick_of(0, 0, 32767, 0));
        send_tick(tick_of(32767, 32767, -32768, 1));
        send_tick(tick_of(-32768, -32768, 32767, 1));

        // zero deadband, top bias, zero control period
        set_drive(1'b1, 0, 32767, 0);
        send_tick(tick_of(32767, 0, 0, 0));
        send_tick(tick_of(-32768, -32768, 0, 0));
        send_tick(tick_of(0, 0, 0, 1));

        // widest deadband, bottom bias
        set_drive(1'b1, 32767, -32768, 1);
        send_tick(tick_of(-32768, -32768, 32767, 1));
        send_tick(tick_of(32767, 32767, -32768, 1));
        send_tick(tick_of(-32768, -32768, 32767, 0));
        send_tick(tick_of(0, 0, 0, 0));

        // disabled drive zeroes duties at the next refresh
        set_drive(1'b0, 50, 0, 1);
        send_tick(tick_of(-500, 0, 0, 0));
        send_tick(tick_of(500, 0, 0, 0));
    endtask

    // Hold one direction while the soft start climbs, then drop enable
    task automatic test_level_saturation();
        set_drive(1'b1, 100, 0, 1000);
        repeat (150) send_tick(tick_for_error(301 + int'($urandom_range(0, 1000))));
        set_drive(1'b0, 100, 0, 1000);
        repeat (25) send_tick(tick_for_error(301 + int'($urandom_range(0, 1000))));
    endtask

    // Random settings per phase, mostly boundary-seeking errors with some noise
    task automatic test_random_phases();
        int db;
        int period;
        int bias;
        bit en;
        for (int p = 0; p < 8; p++)
        begin
            db     = $urandom_range(1, 300);
            period = $urandom_range(1, 6);
            bias   = int'($urandom_range(0, 2000)) - 1000;
            en     = ($urandom_range(0, 4) != 0);
            case (p)
                0: db = 32767;
                1: db = 0;
                2: period = 1000;
                3: bias = -32768;
                4: bias = 32767;
                5: period = 0;
                default: ;
            endcase
            set_drive(en, db, bias, period);
            no_gaps = (p % 3 == 2);
            for (int i = 0; i < 50; i++)
            begin
                if (i == 40 && (p == 0 || $urandom_range(0, 1)))
                    drain_results();
                if ($urandom_range(0, 9) < 8)
                    send_tick(band_probe_tick());
                else
                    send_tick(raw_tick());
            end
        end
        no_gaps = 1'b0;
    endtask

    // Accept results with random stalls and check each against the model
    initial
    begin
        int      stall;
        result_t want;
        wait (rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            if (bridge_outputs_due.size() == 0)
                report_mismatch("unexpected result", int'(result), 0);
            else
            begin
                want = bridge_outputs_due.pop_front();
                if (result.drive_a_duty !== want.drive_a_duty)
                    report_mismatch("drive_a_duty", int'(result.drive_a_duty),
                                    int'(want.drive_a_duty));
                if (result.drive_b_duty !== want.drive_b_duty)
                    report_mismatch("drive_b_duty", int'(result.drive_b_duty),
                                    int'(want.drive_b_duty));
                if (result.motion_dir !== want.motion_dir)
                    report_mismatch("motion_dir", int'(result.motion_dir),
                                    int'(want.motion_dir));
            end
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        drive_cfg.enable_drive      = 1'b0;
        drive_cfg.deadband          = DEADBAND_W'(DEADBAND_RST);
        drive_cfg.position_bias     = '0;
        drive_cfg.control_period_ms = PERIOD_W'(PERIOD_RST);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_edges();
        test_level_saturation();
        test_random_phases();

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && bridge_outputs_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/bbpd_pkg.sv
src/bbpd_cfg_regs.sv
src/bbpd_in_stage.sv
src/bbpd_core.sv
src/bang_bang_position_drive.sv
dv/tb_top.sv
